/* hw/rtl/coet_pkg.sv */
// ----------------------------------------------------------------------------
// coet_pkg: shared types and constants of the clock offset EMA table
// Word layouts of the input and result channels, the decoded command that
// travels between front and back, operation codes and alpha constants.
// ----------------------------------------------------------------------------
`default_nettype none

package coet_pkg;

  // Operation codes of the op field
  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_CONVERT = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_SPARE   = 2'd3;

  // Alpha is an unsigned Q16 fraction; ALPHA_ONE means 1.0
  localparam int unsigned ALPHA_W     = 17;
  localparam logic [16:0] ALPHA_ONE   = 17'd65536;
  localparam logic [16:0] ALPHA_RESET = 17'd6554;

  // Width of the exact blend accumulator
  localparam int unsigned ACC_W = 82;

  // Command kinds after classification
  typedef enum logic [1:0] {
    K_OBSERVE,
    K_CONVERT,
    K_CLEAR,
    K_NOP
  } coet_kind_e;

  // Input word
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  sensor_index;
    logic [63:0] device_time;
    logic [63:0] host_time_in;
  } coet_in_t;

  // Result word
  typedef struct packed {
    logic [63:0]        aligned_time;
    logic signed [63:0] offset_now;
    logic               offset_known;
  } coet_out_t;

  // Classified command queued between front and back
  typedef struct packed {
    coet_kind_e  kind;
    logic [3:0]  sensor_index;
    logic [63:0] device_time;
    logic [63:0] sample;
  } coet_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/coet_fifo.sv */
// ----------------------------------------------------------------------------
// coet_fifo: small register queue
// Holds up to DEPTH words; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module coet_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/coet_front.sv */
// ----------------------------------------------------------------------------
// coet_front: input classifier
// Decodes the operation, checks the sensor range and forms the raw offset
// sample host_time_in - device_time for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module coet_front import coet_pkg::*; #(
  parameter int unsigned SENSORS = 16
) (
  input  wire coet_in_t item_i,
  output coet_cmd_t     cmd_o
);

  logic in_range;

  assign in_range = (32'(item_i.sensor_index) < SENSORS);

  // Classify the word
  always_comb begin
    cmd_o.sensor_index = item_i.sensor_index;
    cmd_o.device_time  = item_i.device_time;
    cmd_o.sample       = item_i.host_time_in - item_i.device_time;
    unique case (item_i.op) inside
      OP_OBSERVE:           cmd_o.kind = in_range ? K_OBSERVE : K_NOP;
      OP_CLEAR:             cmd_o.kind = K_CLEAR;
      OP_CONVERT, OP_SPARE: cmd_o.kind = in_range ? K_CONVERT : K_NOP;
      default:              cmd_o.kind = K_NOP;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/coet_back.sv */
// ----------------------------------------------------------------------------
// coet_back: offset table and blend sequencer
// Holds the offset memory, the known bits and alpha. Executes one command at
// a time; the blend runs four 33x18 partial products through one multiplier
// into an exact accumulator, then rounds half away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module coet_back import coet_pkg::*; #(
  parameter int unsigned SENSORS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [ALPHA_W-1:0] cfg_wdata_i,
  input  wire logic               cmd_empty_i,
  input  wire coet_cmd_t          cmd_i,
  output logic                    cmd_pop_o,
  input  wire logic               res_full_i,
  output logic                    res_push_o,
  output coet_out_t               res_o
);

  localparam int unsigned AW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam logic [2:0]  MAC_LAST = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MAC,
    ST_NEG,
    ST_RND,
    ST_FIN,
    ST_WB,
    ST_OUT
  } state_e;

  state_e               state_q;
  logic [SENSORS-1:0]   known_q;
  logic [ALPHA_W-1:0]   alpha_q;
  logic [2:0]           step_q;

  logic [63:0]          offset_mem [SENSORS];
  logic [63:0]          old_q;
  logic                 hit_q;
  coet_cmd_t            cmd_q;
  coet_out_t            res_q;
  logic [ACC_W-1:0]     prod_q, acc_q, mag_q;
  logic                 neg_q;
  logic [63:0]          q_q, new_q;

  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 rd_en, wr_en;
  logic [63:0]          wr_data;
  logic [ALPHA_W-1:0]   one_minus;
  logic [63:0]          mul_x;
  logic [ALPHA_W-1:0]   mul_w;
  logic [32:0]          mul_a;
  logic signed [50:0]   mul_p;
  logic [ACC_W-1:0]     prod_d, rnd_sum;

  assign rd_addr   = AW'(cmd_i.sensor_index);
  assign wr_addr   = AW'(cmd_q.sensor_index);
  assign rd_en     = (state_q == ST_IDLE) && !cmd_empty_i;
  assign cmd_pop_o = rd_en;
  assign wr_en     = ((state_q == ST_LOOK) && (cmd_q.kind == K_OBSERVE) && !hit_q)
                     || (state_q == ST_WB);
  assign wr_data   = (state_q == ST_WB) ? new_q : cmd_q.sample;
  assign res_push_o = (state_q == ST_OUT);
  assign res_o      = res_q;
  assign one_minus  = ALPHA_ONE - alpha_q;

  // Select one partial product: old by (1 - alpha), then sample by alpha
  assign mul_x = step_q[1] ? cmd_q.sample : old_q;
  assign mul_w = step_q[1] ? alpha_q : one_minus;
  assign mul_a = step_q[0] ? {mul_x[63], mul_x[63:32]} : {1'b0, mul_x[31:0]};
  assign mul_p = $signed(mul_a) * $signed({1'b0, mul_w});
  assign prod_d = step_q[0] ? {mul_p[49:0], 32'd0} : {{31{mul_p[50]}}, mul_p};
  assign rnd_sum = mag_q + ACC_W'(32768);

  // Sequence commands, known bits and alpha
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      known_q <= '0;
      alpha_q <= ALPHA_RESET;
      step_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        alpha_q <= (cfg_wdata_i > ALPHA_ONE) ? ALPHA_ONE : cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!cmd_empty_i) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          step_q <= '0;
          case (cmd_q.kind)
            K_OBSERVE: begin
              if (hit_q) begin
                state_q <= ST_MAC;
              end else begin
                known_q[wr_addr] <= 1'b1;
                state_q <= ST_OUT;
              end
            end
            K_CLEAR: begin
              known_q <= '0;
              state_q <= ST_OUT;
            end
            default: state_q <= ST_OUT;
          endcase
        end
        ST_MAC: begin
          if (step_q == MAC_LAST) begin
            state_q <= ST_NEG;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_NEG: state_q <= ST_RND;
        ST_RND: state_q <= ST_FIN;
        ST_FIN: state_q <= ST_WB;
        ST_WB:  state_q <= ST_OUT;
        ST_OUT: begin
          if (!res_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath: latch the command, accumulate, round and form the result
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cmd_q <= cmd_i;
        hit_q <= ((cmd_i.kind == K_OBSERVE) || (cmd_i.kind == K_CONVERT))
                 && known_q[rd_addr];
      end
      ST_LOOK: begin
        acc_q <= '0;
        if (cmd_q.kind == K_OBSERVE && !hit_q) begin
          res_q.aligned_time <= cmd_q.device_time + cmd_q.sample;
          res_q.offset_now   <= cmd_q.sample;
          res_q.offset_known <= 1'b1;
        end else if (cmd_q.kind == K_CONVERT && hit_q) begin
          res_q.aligned_time <= cmd_q.device_time + old_q;
          res_q.offset_now   <= old_q;
          res_q.offset_known <= 1'b1;
        end else begin
          res_q.aligned_time <= cmd_q.device_time;
          res_q.offset_now   <= '0;
          res_q.offset_known <= 1'b0;
        end
      end
      ST_MAC: begin
        if (step_q != MAC_LAST) begin
          prod_q <= prod_d;
        end
        if (step_q != 3'd0) begin
          acc_q <= acc_q + prod_q;
        end
      end
      ST_NEG: begin
        neg_q <= acc_q[ACC_W-1];
        mag_q <= acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
      end
      ST_RND: q_q   <= rnd_sum[79:16];
      ST_FIN: new_q <= neg_q ? (64'd0 - q_q) : q_q;
      ST_WB: begin
        res_q.aligned_time <= cmd_q.device_time + new_q;
        res_q.offset_now   <= new_q;
        res_q.offset_known <= 1'b1;
      end
      default: ;
    endcase
  end

  // Offset memory: one read, one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      old_q <= offset_mem[rd_addr];
    end
    if (wr_en) begin
      offset_mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/clock_offset_ema_table.sv */
// ----------------------------------------------------------------------------
// clock_offset_ema_table: per-sensor clock offset filter
// Keeps a smoothed host-minus-device offset per sensor and returns device
// times aligned to the host clock.
// ----------------------------------------------------------------------------
//  channel | handshake           | word
//  --------+---------------------+------------------------------------------
//  input   | push / full         | in_item_i  : op, sensor_index, times
//  result  | empty / pop         | out_item_o : aligned_time, offset, known
//  config  | cfg_we_i            | cfg_wdata_i: alpha_q16
//
// Convert, clear, out-of-range and first-sample observe words pass the back end
// through LOOK and OUT; a blended observe also runs the four partial products
// that share one 33x18 multiplier plus the rounding steps. A two-word command
// queue and a two-word result queue sit on either side of the back end.
// Reset clears all known bits and loads alpha with 6554; no clearing pass.
// Input keeps filling the command queue while results wait to be popped.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_offset_ema_table import coet_pkg::*; #(
  parameter int unsigned SENSORS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [ALPHA_W-1:0] cfg_wdata_i,
  input  wire logic               push,
  input  wire coet_in_t           in_item_i,
  output logic                    full,
  input  wire logic               pop,
  output coet_out_t               out_item_o,
  output logic                    empty
);

  localparam int unsigned QUEUE_DEPTH = 2;

  coet_cmd_t cmd_in, cmd_out;
  logic      cmd_empty, cmd_pop;
  coet_out_t res_in;
  logic      res_full, res_push;

  // Classify incoming words
  coet_front #(.SENSORS(SENSORS)) u_front (
    .item_i (in_item_i),
    .cmd_o  (cmd_in)
  );

  // Queue commands between front and back
  coet_fifo #(.WIDTH($bits(coet_cmd_t)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // Execute commands against the offset table
  coet_back #(.SENSORS(SENSORS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Hold results until popped
  coet_fifo #(.WIDTH($bits(coet_out_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire
